>>> hw/rtl/assert_macros.svh
// Assertion macros used by the byte sequencer RTL (dfde_seq).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/dfde_pkg.sv
// Types, constants and fixed-slot table of the display frame encoder.
`default_nettype none

package dfde_pkg;

  localparam int BinWidth  = 16;
  localparam int BcdDigits = 5;
  localparam int BcdWidth  = 4 * BcdDigits;

  localparam logic [7:0] ByteStart = 8'h0A;
  localparam logic [7:0] ByteSep   = 8'hAC;
  localparam logic [7:0] ByteEnd   = 8'h8D;
  localparam logic [3:0] AsciiHigh = 4'h3;

  localparam logic [4:0] LastSlot = 5'd16;

  localparam int TailDepth = 34;

  // Fixed slots in ASCII: "979" | "0" | "53","0","0" | ten "0" | end byte
  localparam logic [7:0] TailRom [0:TailDepth-1] = '{
    8'h39, 8'h37, 8'h39, 8'hAC,
    8'h30, 8'hAC,
    8'h35, 8'h33, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC,
    8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC,
    8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC, 8'h30, 8'hAC,
    8'h8D
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_START,
    ST_DIGIT,
    ST_SEP,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic [5:0] start;
    logic [4:0] len;
  } tail_t;

  function automatic tail_t tail_of(input logic [4:0] slot);
    tail_t t;
    t = '{start: 6'd0, len: 5'd0};
    unique case (slot)
      5'd6:                t = '{start: 6'd0,  len: 5'd4};
      5'd7, 5'd8, 5'd13:   t = '{start: 6'd4,  len: 5'd2};
      5'd15:               t = '{start: 6'd6,  len: 5'd7};
      5'd16:               t = '{start: 6'd13, len: 5'd21};
      default:             t = '{start: 6'd0,  len: 5'd0};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/display_frame_decimal_encoder.sv
// Display frame encoder: one 16-bit value in, its decimal digits and fixed slots out.
// Each accepted value first goes through serial BCD conversion, one bit a cycle, plus
// hand-over, then one byte per cycle when taken, bar skipped leading zeros (0..4).
// A new value is taken only in idle, once the last byte of the previous one is loaded
// into the single byte output register; this and the bit-serial converter set throughput.
// Reset (rst, synchronous, active high) empties the output and sets the frame to slot 0.
`default_nettype none

module display_frame_decimal_encoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  out_byte,
  output logic             last_of_run,
  output logic             end_of_frame
);
  import dfde_pkg::*;

  logic                conv_start;
  logic                conv_done;
  logic [BcdWidth-1:0] conv_bcd;

  // serial shift-and-add-3 conversion of the incoming beat
  dfde_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .bin   (value),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // digit emission, separators, fixed slots and the registered output beat
  dfde_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .conv_start (conv_start),
    .conv_done  (conv_done),
    .conv_bcd   (conv_bcd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (last_of_run),
    .out_eof    (end_of_frame)
  );

endmodule

`default_nettype wire

>>> hw/rtl/dfde_bin2bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
`default_nettype none

module dfde_bin2bcd (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dfde_pkg::BinWidth-1:0] bin,
  output logic                               done,
  output logic      [dfde_pkg::BcdWidth-1:0] bcd
);
  import dfde_pkg::*;

  logic [BinWidth-1:0] bin_sr;
  logic [3:0]          cnt;
  logic                busy;
  logic [BcdWidth-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < BcdDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(BinWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_sr <= bin;
      bcd    <= '0;
    end else if (busy) begin
      bin_sr <= {bin_sr[BinWidth-2:0], 1'b0};
      bcd    <= {adj[BcdWidth-2:0], bin_sr[BinWidth-1]};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dfde_seq.sv
// Byte sequencer: start byte, decimal digits, separators, fixed slots, end byte.
`default_nettype none
`include "assert_macros.svh"

module dfde_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               conv_start,
  input  wire logic                          conv_done,
  input  wire logic [dfde_pkg::BcdWidth-1:0] conv_bcd,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [7:0]                    out_byte,
  output logic                               out_last,
  output logic                               out_eof
);
  import dfde_pkg::*;

  state_t              state, state_next;
  logic [4:0]          slot, slot_next;
  logic [BcdWidth-1:0] digits, digits_next;
  logic [2:0]          dig_cnt, dig_cnt_next;
  logic                started, started_next;
  logic [5:0]          tail_idx, tail_idx_next;
  logic [4:0]          tail_rem, tail_rem_next;
  logic                out_valid_next, out_last_next, out_eof_next;
  logic [7:0]          out_byte_next;
  logic                out_free;
  logic [3:0]          top_dig;
  logic [4:0]          slot_inc;
  logic [7:0]          rom_byte;
  tail_t               tail;

  assign in_ready   = (state == ST_IDLE);
  assign conv_start = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign top_dig    = digits[BcdWidth-1 -: 4];
  assign slot_inc   = (slot == LastSlot) ? 5'd0 : slot + 5'd1;
  assign tail       = tail_of(slot);
  assign rom_byte   = TailRom[tail_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      slot      <= slot_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    digits   <= digits_next;
    dig_cnt  <= dig_cnt_next;
    started  <= started_next;
    tail_idx <= tail_idx_next;
    tail_rem <= tail_rem_next;
    out_byte <= out_byte_next;
    out_last <= out_last_next;
    out_eof  <= out_eof_next;
  end

  always_comb begin
    state_next     = state;
    slot_next      = slot;
    digits_next    = digits;
    dig_cnt_next   = dig_cnt;
    started_next   = started;
    tail_idx_next  = tail_idx;
    tail_rem_next  = tail_rem;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    out_eof_next   = out_eof;

    unique case (state)
      ST_IDLE: begin
        if (conv_start) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          digits_next  = conv_bcd;
          dig_cnt_next = 3'(BcdDigits - 1);
          started_next = 1'b0;
          state_next   = (slot == 5'd0) ? ST_START : ST_DIGIT;
        end
      end
      ST_START: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = ByteStart;
          out_last_next  = 1'b0;
          out_eof_next   = 1'b0;
          state_next     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (!started && top_dig == 4'd0 && dig_cnt != 3'd0) begin
          // leading zero: drop it
          digits_next  = {digits[BcdWidth-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 3'd1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = {AsciiHigh, top_dig};
          out_last_next  = 1'b0;
          out_eof_next   = 1'b0;
          started_next   = 1'b1;
          digits_next    = {digits[BcdWidth-5:0], 4'd0};
          if (dig_cnt == 3'd0) begin
            state_next = ST_SEP;
          end else begin
            dig_cnt_next = dig_cnt - 3'd1;
          end
        end
      end
      ST_SEP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = ByteSep;
          out_eof_next   = 1'b0;
          out_last_next  = (tail.len == 5'd0);
          if (tail.len == 5'd0) begin
            slot_next  = slot_inc;
            state_next = ST_IDLE;
          end else begin
            tail_idx_next = tail.start;
            tail_rem_next = tail.len;
            state_next    = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = rom_byte;
          out_eof_next   = (rom_byte == ByteEnd);
          out_last_next  = (tail_rem == 5'd1);
          tail_idx_next  = tail_idx + 6'd1;
          tail_rem_next  = tail_rem - 5'd1;
          if (tail_rem == 5'd1) begin
            slot_next  = slot_inc;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_slot_range, clk, rst, 1'b1, slot <= LastSlot)
  `ASSERT_IMPL(a_eof_is_last, clk, rst, out_valid && out_eof, out_last)
  `ASSERT_IMPL(a_done_in_conv, clk, rst, conv_done, state == ST_CONV)
  `ASSERT_NEXT(a_accept_to_conv, clk, rst, conv_start, state == ST_CONV)

endmodule

`default_nettype wire
